FILE: hw/rtl/edpd_pkg.sv
package edpd_pkg;

    localparam int MaxWidth      = 4096;
    localparam int ColBits       = 12;
    localparam int PalDepth      = 256;
    localparam int PalBits       = 8;
    localparam int FracBits      = 8;
    localparam int ErrBits       = 19;
    localparam int RowErrBits    = 3 * ErrBits;

    localparam logic signed [ErrBits-1:0] ClampFp = 19'sd76800;

    localparam logic [1:0] PACK_8 = 2'd0;
    localparam logic [1:0] PACK_4 = 2'd1;
    localparam logic [1:0] PACK_1 = 2'd2;

    localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] REG_PALETTE_SIZE = 2'd1;
    localparam logic [1:0] REG_PACK_MODE    = 2'd2;

    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_LAST,
        ST_UPDATE,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] entry_number;
        logic       first_row;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] color_index;
        logic [7:0] packed_byte;
        logic       byte_ready;
        logic       row_end;
    } pixel_out_t;

    // floor(e*w/16) by arithmetic shift
    function automatic logic signed [ErrBits-1:0] share16(
        input logic signed [ErrBits-1:0] e, input logic [2:0] w);
        logic signed [ErrBits+3:0] p;
        begin
            p = $signed({{4{e[ErrBits-1]}}, e}) * $signed({1'b0, w});
            share16 = p[ErrBits+3:4];
        end
    endfunction

endpackage

FILE: hw/rtl/edpd_stream_if.sv
interface edpd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/edpd_cfg_regs.sv
module edpd_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [12:0] row_width,
    output logic [8:0]  palette_size,
    output logic [1:0]  pack_mode
);
    logic [12:0] row_width_reg;
    logic [8:0]  palette_size_reg;
    logic [1:0]  pack_mode_reg;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg    <= 13'd640;
            palette_size_reg <= 9'd256;
            pack_mode_reg    <= edpd_pkg::PACK_8;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                edpd_pkg::REG_ROW_WIDTH:    row_width_reg    <= pwdata[12:0];
                edpd_pkg::REG_PALETTE_SIZE: palette_size_reg <= pwdata[8:0];
                edpd_pkg::REG_PACK_MODE:    pack_mode_reg    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            edpd_pkg::REG_ROW_WIDTH:    prdata = {19'd0, row_width_reg};
            edpd_pkg::REG_PALETTE_SIZE: prdata = {23'd0, palette_size_reg};
            edpd_pkg::REG_PACK_MODE:    prdata = {30'd0, pack_mode_reg};
            default:                    prdata = 32'd0;
        endcase
        if (paddr[1:0] != 2'b00)
            prdata = 32'd0;
    end

    assign row_width    = row_width_reg;
    assign palette_size = palette_size_reg;
    assign pack_mode    = pack_mode_reg;
endmodule

FILE: hw/rtl/error_diffusion_palette_dither_core.sv
// Channel  Dir  Payload
// in_ch    in   edpd_pkg::pixel_in_t   (pixel or palette write)
// out_ch   out  edpd_pkg::pixel_out_t  (one per pixel)
// APB      in   row_width, palette_size, pack_mode at 0x0, 0x4, 0x8
//
// A pixel passes through the accept cycle, the row-memory read, a search step
// for each of N palette entries, N being the clamped palette size, and the
// update; the last pixel of a row adds a step that writes its last column.
// A palette write is done in its accept cycle. After reset a clearing pass
// zeroes all 4096 row error memory entries; nothing is accepted during it.
// The next pixel is accepted while a result waits in the output register;
// the update of that pixel holds until the waiting result is taken.
module error_diffusion_palette_dither_core (
    input  logic        clk,
    input  logic        rst_n,
    edpd_stream_if.sink   in_ch,
    edpd_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int EB = edpd_pkg::ErrBits;
    localparam int CB = edpd_pkg::ColBits;

    logic [12:0] row_width;
    logic [8:0]  palette_size;
    logic [1:0]  pack_mode;

    edpd_cfg_regs u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .row_width, .palette_size, .pack_mode
    );

    // memories
    logic [23:0] pal_mem [edpd_pkg::PalDepth];
    logic [edpd_pkg::RowErrBits-1:0] row_mem [edpd_pkg::MaxWidth];
    logic [23:0] pal_rd;
    logic [edpd_pkg::RowErrBits-1:0] row_rd;
    logic        pal_we, row_we;
    logic [7:0]  pal_waddr, pal_raddr;
    logic [23:0] pal_wdata;
    logic [CB-1:0] row_waddr, row_raddr;
    logic [edpd_pkg::RowErrBits-1:0] row_wdata;

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[pal_waddr] <= pal_wdata;
        pal_rd <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        row_rd <= row_mem[row_raddr];
    end

    // state
    edpd_pkg::state_t state_reg, state_next;
    logic [CB-1:0] clr_reg, clr_next;
    logic [CB-1:0] col_reg, col_next;
    logic [8:0]    idx_reg, idx_next;
    logic [8:0]    cand_reg, cand_next;
    logic [7:0]    best_reg, best_next;
    logic [17:0]   bestd_reg, bestd_next;
    logic          bestv_reg, bestv_next;
    logic [7:0]    pack_reg, pack_next;
    logic          first_row_reg, first_row_next;
    logic [23:0]   pix_reg, pix_next;
    logic [CB-1:0] ccol_reg, ccol_next;
    logic          last_reg, last_next;
    logic signed [EB-1:0] tv_reg [3];
    logic signed [EB-1:0] tv_next [3];
    logic signed [EB-1:0] re_reg [3];
    logic signed [EB-1:0] re_next [3];
    logic signed [EB-1:0] pbl_reg [3];
    logic signed [EB-1:0] pbl_next [3];
    logic signed [EB-1:0] de_reg [3];
    logic signed [EB-1:0] de_next [3];
    logic [7:0]    q_reg [3];
    logic [7:0]    q_next [3];
    logic [23:0]   bestc_reg, bestc_next;
    logic          ov_reg, ov_next;
    edpd_pkg::pixel_out_t od_reg, od_next;
    // pending below-left value before the row-end clear
    logic signed [EB-1:0] pbl_saved [3];
    logic signed [EB-1:0] pbl_saved_next [3];

    // effective sizes
    logic [12:0] eff_w;
    logic [8:0]  eff_n;
    always_comb
    begin
        eff_w = row_width;
        if (eff_w == 13'd0) eff_w = 13'd1;
        if (eff_w > 13'd4096) eff_w = 13'd4096;
        eff_n = palette_size;
        if (eff_n == 9'd0) eff_n = 9'd1;
        if (eff_n > 9'd256) eff_n = 9'd256;
    end

    // distance of candidate read this cycle
    logic [17:0] cand_dist;
    always_comb
    begin
        logic [8:0] d0, d1, d2;
        d0 = 9'({1'b0, pal_rd[7:0]}   - {1'b0, q_reg[0]});
        d1 = 9'({1'b0, pal_rd[15:8]}  - {1'b0, q_reg[1]});
        d2 = 9'({1'b0, pal_rd[23:16]} - {1'b0, q_reg[2]});
        cand_dist = 18'($signed(d0) * $signed(d0)) + 18'($signed(d1) * $signed(d1))
                  + 18'($signed(d2) * $signed(d2));
    end

    logic in_fire, out_fire;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    // control and datapath
    always_comb
    begin
        logic signed [EB-1:0] row_e;
        logic signed [EB+1:0] t;
        logic signed [EB-1:0] tt;
        logic signed [EB-1:0] err;
        logic [EB-1:0] rr;
        logic [12:0] c13;
        logic        rdy;
        logic [1:0]  md;
        state_next = state_reg;
        clr_next = clr_reg; col_next = col_reg; idx_next = idx_reg;
        cand_next = cand_reg; best_next = best_reg; bestd_next = bestd_reg;
        bestv_next = bestv_reg; pack_next = pack_reg;
        first_row_next = first_row_reg; pix_next = pix_reg; ccol_next = ccol_reg;
        last_next = last_reg; bestc_next = bestc_reg;
        ov_next = ov_reg && !out_fire; od_next = od_reg;
        for (int k = 0; k < 3; k++)
        begin
            tv_next[k] = tv_reg[k]; re_next[k] = re_reg[k];
            pbl_next[k] = pbl_reg[k]; de_next[k] = de_reg[k]; q_next[k] = q_reg[k];
        end
        pal_we = 1'b0; pal_waddr = in_ch.payload.entry_number;
        pal_wdata = {in_ch.payload.red, in_ch.payload.green, in_ch.payload.blue};
        pal_raddr = idx_reg[7:0];
        row_we = 1'b0; row_waddr = clr_reg; row_wdata = '0; row_raddr = col_reg;
        in_ch.ready = 1'b0;
        c13 = 13'd0; rdy = 1'b0; md = 2'd0; err = '0; row_e = '0; t = '0;
        tt = '0; rr = '0;
        case (state_reg)
            edpd_pkg::ST_CLEAR:
            begin
                row_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CB'(edpd_pkg::MaxWidth - 1))
                    state_next = edpd_pkg::ST_IDLE;
            end
            edpd_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                c13 = {1'b0, col_reg};
                if (c13 >= eff_w) c13 = eff_w - 13'd1;
                row_raddr = c13[CB-1:0];
                if (in_fire)
                begin
                    if (in_ch.payload.req_type == edpd_pkg::REQ_PALETTE)
                        pal_we = 1'b1;
                    else
                    begin
                        ccol_next = c13[CB-1:0];
                        last_next = (c13 == eff_w - 13'd1);
                        first_row_next = in_ch.payload.first_row;
                        pix_next = {in_ch.payload.red, in_ch.payload.green,
                                    in_ch.payload.blue};
                        state_next = edpd_pkg::ST_READ;
                    end
                end
            end
            edpd_pkg::ST_READ:
            begin
                // row error ready: form true values
                for (int k = 0; k < 3; k++)
                begin
                    row_e = first_row_reg ? '0 : $signed(row_rd[k*EB +: EB]);
                    t = (EB+2)'(row_e) + (EB+2)'(re_reg[k])
                      + $signed({3'b0, pix_reg[k*8 +: 8], 8'd0});
                    if (t > (EB+2)'(edpd_pkg::ClampFp)) tt = edpd_pkg::ClampFp;
                    else if (t < -(EB+2)'(edpd_pkg::ClampFp)) tt = -edpd_pkg::ClampFp;
                    else tt = t[EB-1:0];
                    tv_next[k] = tt;
                    if (tt <= 0) q_next[k] = 8'd0;
                    else
                    begin
                        rr = EB'(tt + 19'sd128) >> 8;
                        q_next[k] = (rr > 255) ? 8'd255 : rr[7:0];
                    end
                end
                idx_next = 9'd1; pal_raddr = 8'd0; cand_next = 9'd0;
                bestv_next = 1'b0; best_next = 8'd0;
                state_next = edpd_pkg::ST_SEARCH;
            end
            edpd_pkg::ST_SEARCH:
            begin
                // pal_rd holds entry cand_reg
                if (!bestv_reg || cand_dist < bestd_reg)
                begin
                    bestd_next = cand_dist; best_next = cand_reg[7:0];
                    bestc_next = pal_rd; bestv_next = 1'b1;
                end
                cand_next = cand_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (cand_reg + 9'd1 == eff_n)
                    state_next = edpd_pkg::ST_UPDATE;
            end
            edpd_pkg::ST_UPDATE:
            begin
                if (!ov_reg || out_fire)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        err = tv_reg[k] - $signed({3'b0, bestc_reg[k*8 +: 8], 8'd0});
                        row_wdata[k*EB +: EB] = pbl_reg[k] + edpd_pkg::share16(err, 3'd3);
                        pbl_next[k] = edpd_pkg::share16(err, 3'd5) + de_reg[k];
                        de_next[k] = edpd_pkg::share16(err, 3'd1);
                        re_next[k] = last_reg ? '0 : edpd_pkg::share16(err, 3'd7);
                        if (last_reg)
                        begin
                            pbl_next[k] = '0; de_next[k] = '0;
                        end
                    end
                    row_waddr = ccol_reg - 1'b1;
                    row_we = (ccol_reg != '0);
                    if (last_reg)
                        state_next = edpd_pkg::ST_LAST;
                    else
                        state_next = edpd_pkg::ST_IDLE;
                    // packing
                    md = (pack_mode == 2'd3) ? edpd_pkg::PACK_8 : pack_mode;
                    case (md)
                        edpd_pkg::PACK_4:
                        begin
                            pack_next = pack_reg | (ccol_reg[0] ? {4'd0, best_reg[3:0]}
                                                                : {best_reg[3:0], 4'd0});
                            rdy = ccol_reg[0] || last_reg;
                        end
                        edpd_pkg::PACK_1:
                        begin
                            pack_next = pack_reg | (8'(best_reg[0]) << (3'd7 - ccol_reg[2:0]));
                            rdy = (ccol_reg[2:0] == 3'd7) || last_reg;
                        end
                        default:
                        begin
                            pack_next = best_reg;
                            rdy = 1'b1;
                        end
                    endcase
                    od_next.color_index = best_reg;
                    od_next.packed_byte = rdy ? pack_next : 8'd0;
                    od_next.byte_ready = rdy;
                    od_next.row_end = last_reg;
                    if (rdy) pack_next = 8'd0;
                    ov_next = 1'b1;
                    col_next = last_reg ? '0 : ccol_reg + 1'b1;
                end
            end
            edpd_pkg::ST_LAST:
            begin
                // last column stores the pending below-left share
                row_we = 1'b1;
                row_waddr = ccol_reg;
                for (int k = 0; k < 3; k++)
                    row_wdata[k*EB +: EB] = pbl_saved[k];
                state_next = edpd_pkg::ST_IDLE;
            end
            default: state_next = edpd_pkg::ST_IDLE;
        endcase
    end

    // below-left share kept for the row-end write
    always_comb
    begin
        logic signed [EB-1:0] e2;
        for (int k = 0; k < 3; k++)
        begin
            e2 = tv_reg[k] - $signed({3'b0, bestc_reg[k*8 +: 8], 8'd0});
            pbl_saved_next[k] = edpd_pkg::share16(e2, 3'd5) + de_reg[k];
        end
    end
    always_ff @(posedge clk)
    begin
        if (state_reg == edpd_pkg::ST_UPDATE)
            for (int k = 0; k < 3; k++)
                pbl_saved[k] <= pbl_saved_next[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edpd_pkg::ST_CLEAR;
            clr_reg <= '0; col_reg <= '0; pack_reg <= '0; ov_reg <= 1'b0;
            bestv_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                re_reg[k] <= '0; pbl_reg[k] <= '0; de_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next; col_reg <= col_next; pack_reg <= pack_next;
            ov_reg <= ov_next; bestv_reg <= bestv_next;
            for (int k = 0; k < 3; k++)
            begin
                re_reg[k] <= re_next[k]; pbl_reg[k] <= pbl_next[k];
                de_reg[k] <= de_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next; cand_reg <= cand_next; best_reg <= best_next;
        bestd_reg <= bestd_next; first_row_reg <= first_row_next;
        pix_reg <= pix_next; ccol_reg <= ccol_next; last_reg <= last_next;
        bestc_reg <= bestc_next; od_reg <= od_next;
        for (int k = 0; k < 3; k++)
        begin
            tv_reg[k] <= tv_next[k]; q_reg[k] <= q_next[k];
        end
    end

    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = od_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == edpd_pkg::ST_CLEAR |-> !in_ch.ready)
        else $error("input accepted during clear");
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == edpd_pkg::ST_UPDATE && (!ov_reg || out_fire) && last_reg
        |=> col_reg == '0)
        else $error("column not reset at row end");
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == edpd_pkg::ST_SEARCH |-> cand_reg < eff_n)
        else $error("search past palette size");
`endif
endmodule
